// ===== rtl/ctd_pkg.sv =====
// Shared types, constants and the BCD lookup table for the countdown display.
// No dependencies; the modules of the block import this package.
package ctd_pkg;

   // Display mode, also the code on the result word's mode field
   typedef enum logic [1:0] {
      MODE_EDIT    = 2'd0,
      MODE_RUN     = 2'd1,
      MODE_EXPIRED = 2'd2,
      MODE_IDLE    = 2'd3
   } mode_type;

   // Register map of the configuration port
   typedef enum logic [1:0] {
      REG_DURATION = 2'd0,
      REG_HOURS    = 2'd1,
      REG_MINUTES  = 2'd2,
      REG_SECONDS  = 2'd3
   } reg_index_type;

   // Edit field codes; the fourth code selects nothing
   localparam logic [1:0] FIELD_HOURS   = 2'd0;
   localparam logic [1:0] FIELD_MINUTES = 2'd1;
   localparam logic [1:0] FIELD_SECONDS = 2'd2;
   localparam logic [1:0] FIELD_NONE    = 2'd3;

   localparam logic [31:0] MS_PER_CENTI         = 32'd10;
   localparam logic [31:0] MS_PER_SECOND        = 32'd1000;
   localparam logic [31:0] MS_PER_MINUTE        = 32'd60000;
   localparam logic [31:0] MS_PER_HOUR          = 32'd3600000;
   localparam logic [31:0] MS_PER_HUNDRED_HOURS = 32'd360000000;
   localparam logic [31:0] BLINK_HALF_MS        = 32'd500;

   localparam logic [6:0] HOUR_WRAP     = 7'd100;
   localparam logic [6:0] MIN_PER_HOUR  = 7'd60;
   localparam logic [6:0] SEC_PER_MIN   = 7'd60;
   localparam logic [6:0] CENTI_PER_SEC = 7'd100;

   // floor(2^32 / k): the product with a 32-bit value, shifted down by 32,
   // is the quotient or one short of it
   localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;
   localparam logic [28:0] RECIP_CENTI   = 29'(TWO_POW_32 / 64'(MS_PER_CENTI));
   localparam logic [22:0] RECIP_SECOND  = 23'(TWO_POW_32 / 64'(MS_PER_SECOND));
   localparam logic [16:0] RECIP_MINUTE  = 17'(TWO_POW_32 / 64'(MS_PER_MINUTE));
   localparam logic [10:0] RECIP_HOUR    = 11'(TWO_POW_32 / 64'(MS_PER_HOUR));
   localparam logic [3:0]  RECIP_HUNDRED = 4'(TWO_POW_32 / 64'(MS_PER_HUNDRED_HOURS));
   localparam logic [23:0] RECIP_BLINK   = 24'(TWO_POW_32 / 64'(BLINK_HALF_MS));

   // Two BCD digits for every 7-bit value: tens taken modulo ten
   localparam int PAIR_VALUES = 128;
   typedef logic [PAIR_VALUES-1:0][7:0] bcd_table_type;

   function automatic bcd_table_type build_bcd_table();
      bcd_table_type t;
      logic [3:0]    tens;
      logic [3:0]    units;
      tens  = 4'd0;
      units = 4'd0;
      for (int i = 0; i < PAIR_VALUES; i++) begin
         t[i] = {tens, units};
         if (units == 4'd9) begin
            units = 4'd0;
            if (tens == 4'd9) begin
               tens = 4'd0;
            end else begin
               tens = tens + 4'd1;
            end
         end else begin
            units = units + 4'd1;
         end
      end
      return t;
   endfunction

   localparam bcd_table_type BCD_TABLE = build_bcd_table();

   // What travels alongside the time split to the display stage
   typedef struct packed {
      logic [31:0] remaining;
      mode_type    mode;
      logic        buzz;
      logic [1:0]  edit_field;
      logic [6:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] now;
   } timer_word_type;

   typedef struct packed {
      side_type   side;
      logic       blink_off;
      logic [6:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [6:0] centis;
   } split_word_type;

endpackage

// ===== rtl/ctd_if.sv =====
// Channel interfaces of the countdown display: refresh input, display
// result and register write port. Plain widths, no package dependency.
interface ctd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        editing;
   logic [1:0]  edit_field;
   logic [6:0]  edit_hours;
   logic [5:0]  edit_minutes;
   logic [5:0]  edit_seconds;
   logic        start_req;

   modport source (
      output valid, now_ms, editing, edit_field, edit_hours, edit_minutes,
             edit_seconds, start_req,
      input  ready
   );
   modport sink (
      input  valid, now_ms, editing, edit_field, edit_hours, edit_minutes,
             edit_seconds, start_req,
      output ready
   );
endinterface

interface ctd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digit_codes;
   logic [7:0]  blank_mask;
   logic        buzzer_fire;
   logic [31:0] remaining_ms;
   logic [1:0]  mode;

   modport source (
      output valid, digit_codes, blank_mask, buzzer_fire, remaining_ms, mode,
      input  ready
   );
   modport sink (
      input  valid, digit_codes, blank_mask, buzzer_fire, remaining_ms, mode,
      output ready
   );
endinterface

interface ctd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/countdown_timer_digit_display.sv =====
// Countdown timer display. Each refresh word carries the millisecond clock,
// the edit values and a start flag; the block keeps the countdown state and
// answers with one display word: eight BCD digits, a blank mask, the buzzer
// pulse, the remaining time and the mode. A new refresh word is taken every
// clock cycle unless back-pressure from the output holds the pipeline. The
// countdown state (two 32-bit subtracts and a compare) settles in the cycle a
// word is taken, and the split into HH MM SS cc runs through a three-stage
// reciprocal multiply pipeline ahead of the output register. Register writes
// take effect at once and are meant for when no refresh is in flight.
// Depends on ctd_pkg, ctd_if, ctd_timer, ctd_split and ctd_render.
module countdown_timer_digit_display import ctd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ctd_req_if.sink   req_port,
   ctd_rsp_if.source rsp_port,
   ctd_csr_if.sink   csr_port
);

   logic           timer_valid;
   logic           split_ready;
   timer_word_type timer_word;
   logic           split_valid;
   logic           render_ready;
   split_word_type split_word;

   ctd_timer u_timer (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .csr_port  (csr_port),
      .out_valid (timer_valid),
      .out_ready (split_ready),
      .out_word  (timer_word)
   );

   ctd_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (timer_valid),
      .in_ready  (split_ready),
      .in_word   (timer_word),
      .out_valid (split_valid),
      .out_ready (render_ready),
      .out_word  (split_word)
   );

   ctd_render u_render (
      .clock    (clock),
      .reset    (reset),
      .in_valid (split_valid),
      .in_ready (render_ready),
      .in_word  (split_word),
      .rsp_port (rsp_port)
   );

`ifndef SYNTHESIS
   // the buzzer only sounds on the expiry word
   a_buzz_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.buzzer_fire |-> rsp_port.mode == MODE_EXPIRED)
      else $error("buzzer fired outside expiry");

   // once expired the display and the remaining time are all zeros
   a_expired_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.mode == MODE_EXPIRED
      |-> rsp_port.digit_codes == 32'd0 && rsp_port.remaining_ms == 32'd0)
      else $error("expired word not cleared");

   // a running countdown always has time left
   a_run_left: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.mode == MODE_RUN |-> rsp_port.remaining_ms != 32'd0)
      else $error("running with nothing left");

   // blanking belongs to edit mode only
   a_blank_edit: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.mode != MODE_EDIT |-> rsp_port.blank_mask == 8'd0)
      else $error("blanking outside edit mode");
`endif

endmodule

// ===== rtl/ctd_timer.sv =====
// Register file and countdown state: updates running/start/remaining/expired
// on each accepted refresh word. Depends on ctd_pkg and ctd_if.
module ctd_timer import ctd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   ctd_req_if.sink        req_port,
   ctd_csr_if.sink        csr_port,
   output logic           out_valid,
   input  logic           out_ready,
   output timer_word_type out_word
);

   logic [31:0]    duration_ff;
   logic [6:0]     init_hours_ff;
   logic [5:0]     init_minutes_ff;
   logic [5:0]     init_seconds_ff;

   logic           running_ff, running_in;
   logic [31:0]    start_time_ff, start_time_in;
   logic [31:0]    remaining_ff, remaining_in;
   logic           expired_ff, expired_in;

   logic           valid_ff;
   timer_word_type word_ff, word_in;

   logic           accept;
   logic           run_s;
   logic [31:0]    rem_s;
   logic           exp_s;
   logic [31:0]    elapsed;
   logic           done;

   assign req_port.ready = !valid_ff || out_ready;
   assign accept         = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff     <= '0;
         init_hours_ff   <= '0;
         init_minutes_ff <= '0;
         init_seconds_ff <= '0;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            REG_DURATION: duration_ff     <= csr_port.data;
            REG_HOURS:    init_hours_ff   <= csr_port.data[6:0];
            REG_MINUTES:  init_minutes_ff <= csr_port.data[5:0];
            REG_SECONDS:  init_seconds_ff <= csr_port.data[5:0];
         endcase
      end
   end

   // start acts first, then the mode is resolved on the updated state
   always_comb begin
      run_s         = running_ff;
      start_time_in = start_time_ff;
      rem_s         = remaining_ff;
      exp_s         = expired_ff;
      if (req_port.start_req) begin
         run_s         = 1'b1;
         start_time_in = req_port.now_ms;
         rem_s         = duration_ff;
         exp_s         = 1'b0;
      end

      elapsed = req_port.now_ms - start_time_in;
      done    = elapsed >= duration_ff;

      running_in   = run_s;
      remaining_in = rem_s;
      expired_in   = exp_s;
      word_in.side.buzz = 1'b0;

      if (req_port.editing) begin
         word_in.side.mode = MODE_EDIT;
      end else if (run_s) begin
         if (done) begin
            running_in        = 1'b0;
            remaining_in      = '0;
            expired_in        = 1'b1;
            word_in.side.buzz = 1'b1;
            word_in.side.mode = MODE_EXPIRED;
         end else begin
            remaining_in      = duration_ff - elapsed;
            word_in.side.mode = MODE_RUN;
         end
      end else if (exp_s) begin
         word_in.side.mode = MODE_EXPIRED;
      end else begin
         word_in.side.mode = MODE_IDLE;
      end

      word_in.side.remaining  = remaining_in;
      word_in.side.edit_field = req_port.edit_field;
      word_in.side.hours   = req_port.editing ? req_port.edit_hours   : init_hours_ff;
      word_in.side.minutes = req_port.editing ? req_port.edit_minutes : init_minutes_ff;
      word_in.side.seconds = req_port.editing ? req_port.edit_seconds : init_seconds_ff;
      word_in.now          = req_port.now_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         start_time_ff <= '0;
         remaining_ff  <= '0;
         expired_ff    <= 1'b0;
      end else if (accept) begin
         running_ff    <= running_in;
         start_time_ff <= start_time_in;
         remaining_ff  <= remaining_in;
         expired_ff    <= expired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/ctd_split.sv =====
// Splits remaining milliseconds into hours, minutes, seconds and centiseconds
// and finds the blink phase, by reciprocal multiplication over three stages.
// Depends on ctd_pkg.
module ctd_split import ctd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  timer_word_type in_word,
   output logic           out_valid,
   input  logic           out_ready,
   output split_word_type out_word
);

   // stage A: quotient estimates
   logic           a_valid_ff;
   logic           a_ready;
   side_type       a_side_ff;
   logic [31:0]    a_now_ff;
   logic [28:0]    a_qc_ff;
   logic [22:0]    a_qs_ff;
   logic [16:0]    a_qm_ff;
   logic [10:0]    a_qh_ff;
   logic [3:0]     a_qhh_ff;
   logic [23:0]    a_qb_ff;

   logic [60:0]    prod_c;
   logic [54:0]    prod_s;
   logic [48:0]    prod_m;
   logic [42:0]    prod_h;
   logic [35:0]    prod_hh;
   logic [55:0]    prod_b;

   // stage B: corrected quotients
   logic           b_valid_ff;
   logic           b_ready;
   side_type       b_side_ff;
   logic [28:0]    b_qc_ff, b_qc_in;
   logic [22:0]    b_qs_ff, b_qs_in;
   logic [16:0]    b_qm_ff, b_qm_in;
   logic [10:0]    b_qh_ff, b_qh_in;
   logic [3:0]     b_qhh_ff, b_qhh_in;
   logic           b_blink_ff, b_blink_in;

   logic [31:0]    diff_c, diff_s, diff_m, diff_h, diff_hh, diff_b;

   // stage C: wrapped fields
   logic           c_valid_ff;
   logic           c_ready;
   split_word_type c_word_ff, c_word_in;

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign prod_c  = 61'(in_word.side.remaining) * 61'(RECIP_CENTI);
   assign prod_s  = 55'(in_word.side.remaining) * 55'(RECIP_SECOND);
   assign prod_m  = 49'(in_word.side.remaining) * 49'(RECIP_MINUTE);
   assign prod_h  = 43'(in_word.side.remaining) * 43'(RECIP_HOUR);
   assign prod_hh = 36'(in_word.side.remaining) * 36'(RECIP_HUNDRED);
   assign prod_b  = 56'(in_word.now) * 56'(RECIP_BLINK);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_side_ff <= in_word.side;
         a_now_ff  <= in_word.now;
         a_qc_ff   <= prod_c[60:32];
         a_qs_ff   <= prod_s[54:32];
         a_qm_ff   <= prod_m[48:32];
         a_qh_ff   <= prod_h[42:32];
         a_qhh_ff  <= prod_hh[35:32];
         a_qb_ff   <= prod_b[55:32];
      end
   end

   // each estimate is exact or one short; the remainder tells which
   always_comb begin
      diff_c  = a_side_ff.remaining - 32'(a_qc_ff) * MS_PER_CENTI;
      diff_s  = a_side_ff.remaining - 32'(a_qs_ff) * MS_PER_SECOND;
      diff_m  = a_side_ff.remaining - 32'(a_qm_ff) * MS_PER_MINUTE;
      diff_h  = a_side_ff.remaining - 32'(a_qh_ff) * MS_PER_HOUR;
      diff_hh = a_side_ff.remaining - 32'(a_qhh_ff) * MS_PER_HUNDRED_HOURS;
      diff_b  = a_now_ff - 32'(a_qb_ff) * BLINK_HALF_MS;

      b_qc_in    = a_qc_ff + 29'(diff_c >= MS_PER_CENTI);
      b_qs_in    = a_qs_ff + 23'(diff_s >= MS_PER_SECOND);
      b_qm_in    = a_qm_ff + 17'(diff_m >= MS_PER_MINUTE);
      b_qh_in    = a_qh_ff + 11'(diff_h >= MS_PER_HOUR);
      b_qhh_in   = a_qhh_ff + 4'(diff_hh >= MS_PER_HUNDRED_HOURS);
      b_blink_in = a_qb_ff[0] ^ (diff_b >= BLINK_HALF_MS);
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         b_side_ff  <= a_side_ff;
         b_qc_ff    <= b_qc_in;
         b_qs_ff    <= b_qs_in;
         b_qm_ff    <= b_qm_in;
         b_qh_ff    <= b_qh_in;
         b_qhh_ff   <= b_qhh_in;
         b_blink_ff <= b_blink_in;
      end
   end

   // each field is its quotient less the next coarser quotient times the wrap
   always_comb begin
      c_word_in.side      = b_side_ff;
      c_word_in.blink_off = b_blink_ff;
      c_word_in.hours   = 7'(b_qh_ff - 11'(b_qhh_ff) * 11'(HOUR_WRAP));
      c_word_in.minutes = 6'(b_qm_ff - 17'(b_qh_ff) * 17'(MIN_PER_HOUR));
      c_word_in.seconds = 6'(b_qs_ff - 23'(b_qm_ff) * 23'(SEC_PER_MIN));
      c_word_in.centis  = 7'(b_qc_ff - 29'(b_qs_ff) * 29'(CENTI_PER_SEC));
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff && c_ready) begin
         c_word_ff <= c_word_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_word  = c_word_ff;

endmodule

// ===== rtl/ctd_render.sv =====
// Display stage: picks the digit pairs by mode, applies edit blinking and
// holds the result word. Depends on ctd_pkg and ctd_if.
module ctd_render import ctd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  split_word_type in_word,
   ctd_rsp_if.source      rsp_port
);

   logic        valid_ff;
   logic [31:0] digits_ff, digits_in;
   logic [7:0]  blank_ff, blank_in;
   logic        buzz_ff;
   logic [31:0] remaining_ff;
   mode_type    mode_ff;

   logic [6:0]  hours_v;
   logic [6:0]  minutes_v;
   logic [6:0]  seconds_v;
   logic [6:0]  centis_v;
   logic        blink_off;
   logic [31:0] pair_codes;
   logic [31:0] nibble_mask;

   assign in_ready  = !valid_ff || rsp_port.ready;
   assign blink_off = in_word.blink_off;

   always_comb begin
      hours_v   = in_word.side.hours;
      minutes_v = {1'b0, in_word.side.minutes};
      seconds_v = {1'b0, in_word.side.seconds};
      centis_v  = '0;
      blank_in  = '0;
      unique case (in_word.side.mode) inside
         MODE_RUN: begin
            hours_v   = in_word.hours;
            minutes_v = {1'b0, in_word.minutes};
            seconds_v = {1'b0, in_word.seconds};
            centis_v  = in_word.centis;
         end
         MODE_EDIT: begin
            if (blink_off) begin
               case (in_word.side.edit_field)
                  FIELD_HOURS:   blank_in = 8'hC0;
                  FIELD_MINUTES: blank_in = 8'h30;
                  FIELD_SECONDS: blank_in = 8'h0C;
                  default:       blank_in = 8'h00;
               endcase
            end
         end
         MODE_EXPIRED, MODE_IDLE: begin
         end
      endcase

      pair_codes = {BCD_TABLE[hours_v], BCD_TABLE[minutes_v],
                    BCD_TABLE[seconds_v], BCD_TABLE[centis_v]};
      for (int i = 0; i < 8; i++) begin
         nibble_mask[4*i +: 4] = {4{blank_in[i]}};
      end

      if (in_word.side.mode == MODE_EXPIRED) begin
         digits_in = '0;
      end else begin
         digits_in = pair_codes & ~nibble_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         digits_ff    <= digits_in;
         blank_ff     <= blank_in;
         buzz_ff      <= in_word.side.buzz;
         remaining_ff <= in_word.side.remaining;
         mode_ff      <= in_word.side.mode;
      end
   end

   assign rsp_port.valid        = valid_ff;
   assign rsp_port.digit_codes  = digits_ff;
   assign rsp_port.blank_mask   = blank_ff;
   assign rsp_port.buzzer_fire  = buzz_ff;
   assign rsp_port.remaining_ms = remaining_ff;
   assign rsp_port.mode         = mode_ff;

endmodule
